[src/cid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_pkg
// Shared types, status codes and width helpers for the checked integer divider.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int DataWidth = 64;

  // Width select codes (low two bits of the mode).
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Payload carried down the divide pipeline.
  typedef struct packed {
    logic [DataWidth-1:0] rem;     // partial remainder
    logic [DataWidth-1:0] quo;     // dividend bits still to shift in, quotient bits shifted in
    logic [DataWidth-1:0] div;     // divisor magnitude
    logic [1:0]           wsel;    // operand width select
    logic                 neg;     // quotient must be negated
    logic [1:0]           status;  // error status found up front
  } cid_stage_t;

  function automatic logic [DataWidth-1:0] width_mask(input logic [1:0] wsel);
    logic [DataWidth-1:0] m;
    begin
      case (wsel)
        WSEL_8:  m = 64'h0000_0000_0000_00FF;
        WSEL_16: m = 64'h0000_0000_0000_FFFF;
        WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
        WSEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
        default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
    end
  endfunction

endpackage

[src/cid_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_ifs
// Valid/ready channels for the divider: operation words in, result words out.
// ----------------------------------------------------------------------------
interface cid_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] dividend;
  logic [63:0] divisor;

  modport source (output valid, output mode, output dividend, output divisor, input ready);
  modport sink   (input valid, input mode, input dividend, input divisor, output ready);
endinterface

interface cid_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient;
  logic [1:0]  status;

  modport source (output valid, output quotient, output status, input ready);
  modport sink   (input valid, input quotient, input status, output ready);
endinterface

[src/checked_integer_divider_top.sv]
`timescale 1ns / 1ps
// Pipeline: an operation word passes through 66 register stages (one prepare,
// 64 single-bit divide, one output) from the edge that accepts it to the output.
// Throughput: one word per cycle while the output is not stalled; the 64-stage
// restoring divide pipeline sets this. An output stall freezes the whole pipeline.
// Reset: rst is synchronous and active high; it clears every valid bit, so the
// pipeline comes out of reset empty. Data registers are not reset.
// ----------------------------------------------------------------------------
// checked_integer_divider_top
// Pipelined signed/unsigned 8/16/32/64-bit integer divider with zero-divisor
// and signed-overflow checks.
// ----------------------------------------------------------------------------
module checked_integer_divider_top
  import cid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cid_in_if.sink    din,
  cid_out_if.source dout
);

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its word is being taken this cycle, so a stall at
  // the output freezes every stage in place and nothing is lost or repeated.
  // A new word is taken on every cycle that the pipeline advances.
  logic en;

  // Stage k holds the state after k quotient bits have been produced.
  logic       stage_valid [0:DataWidth];
  cid_stage_t stage       [0:DataWidth];

  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  // Masking, absolute values and the error checks happen up front. The
  // error status then rides along with the word; the divide steps still run
  // on an erroneous word, and the output stage forces its quotient to zero.
  cid_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (din.valid),
    .mode      (din.mode),
    .dividend  (din.dividend),
    .divisor   (din.divisor),
    .out_valid (stage_valid[0]),
    .out_stage (stage[0])
  );

  // One quotient bit per stage, most significant first. Narrow widths are
  // zero-extended magnitudes, so the same 64 steps give the right quotient.
  for (genvar k = 0; k < DataWidth; k++) begin : g_step
    cid_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[k]),
      .in_stage  (stage[k]),
      .out_valid (stage_valid[k+1]),
      .out_stage (stage[k+1])
    );
  end

  // Sign fix-up and width masking; this register is the output register.
  cid_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stage_valid[DataWidth]),
    .in_stage  (stage[DataWidth]),
    .out_valid (dout.valid),
    .quotient  (dout.quotient),
    .status    (dout.status)
  );

endmodule

[src/cid_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_prep
// Front stage: masks operands, takes magnitudes and flags error cases.
// ----------------------------------------------------------------------------
module cid_prep
  import cid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2:0]        mode,
  input  logic [63:0]       dividend,
  input  logic [63:0]       divisor,
  output logic              out_valid,
  output cid_stage_t        out_stage
);

  logic [63:0] mask;
  logic [63:0] topbit;
  logic [63:0] a;
  logic [63:0] b;
  logic        sgn;
  logic        a_neg;
  logic        b_neg;
  cid_stage_t  stage_next;

  always_comb begin
    mask   = width_mask(mode[1:0]);
    topbit = mask ^ (mask >> 1);
    a      = dividend & mask;
    b      = divisor & mask;
    sgn    = mode[2];
    a_neg  = sgn && ((a & topbit) != 64'd0);
    b_neg  = sgn && ((b & topbit) != 64'd0);

    stage_next.rem  = 64'd0;
    stage_next.quo  = a_neg ? ((~a + 64'd1) & mask) : a;
    stage_next.div  = b_neg ? ((~b + 64'd1) & mask) : b;
    stage_next.wsel = mode[1:0];
    stage_next.neg  = a_neg ^ b_neg;
    if (b == 64'd0) begin
      stage_next.status = STATUS_DIV_ZERO;
    end else if (sgn && (a == topbit) && (b == mask)) begin
      stage_next.status = STATUS_OVERFLOW;
    end else begin
      stage_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

[src/cid_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_step
// One restoring division step: yields one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cid_step
  import cid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  cid_stage_t in_stage,
  output logic       out_valid,
  output cid_stage_t out_stage
);

  logic [DataWidth:0]   rem_sh;
  logic [DataWidth:0]   diff;
  logic                 qbit;
  cid_stage_t           stage_next;

  always_comb begin
    rem_sh = {in_stage.rem, in_stage.quo[DataWidth-1]};
    diff   = rem_sh - {1'b0, in_stage.div};
    qbit   = ~diff[DataWidth];

    stage_next     = in_stage;
    stage_next.rem = qbit ? diff[DataWidth-1:0] : rem_sh[DataWidth-1:0];
    stage_next.quo = {in_stage.quo[DataWidth-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

[src/cid_post.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cid_post
// Back stage: applies the sign, masks to width and registers the result word.
// ----------------------------------------------------------------------------
module cid_post
  import cid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  cid_stage_t  in_stage,
  output logic        out_valid,
  output logic [63:0] quotient,
  output logic [1:0]  status
);

  logic [63:0] q_signed;
  logic [63:0] quotient_next;

  always_comb begin
    q_signed = in_stage.neg ? (~in_stage.quo + 64'd1) : in_stage.quo;
    if (in_stage.status != STATUS_OK) begin
      quotient_next = 64'd0;
    end else begin
      quotient_next = q_signed & width_mask(in_stage.wsel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= quotient_next;
      status   <= in_stage.status;
    end
  end

endmodule
